// ===== hdl/lmat_pkg.sv =====
// Shared types and constants for the local maximum detector.
package lmat_pkg;

  localparam int DIM_W = 13;
  localparam int CNT_W = 25;
  localparam int THR_W = 32;
  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;
  localparam int REG_SEL_W = 3;

  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = 2;
  localparam int Q_CNT_W = 3;

  localparam logic [DIM_W-1:0] DIM_MIN = 13'd3;

  localparam logic [REG_SEL_W-1:0] REG_THRESHOLD = 3'd0;
  localparam logic [REG_SEL_W-1:0] REG_EIGHT_NEIGHBOURS = 3'd1;
  localparam logic [REG_SEL_W-1:0] REG_MAX_PEAKS = 3'd2;
  localparam logic [REG_SEL_W-1:0] REG_FRAME_ROWS = 3'd3;
  localparam logic [REG_SEL_W-1:0] REG_FRAME_COLS = 3'd4;

  localparam logic [THR_W-1:0] THRESHOLD_RESET = 32'd137626;
  localparam logic [CNT_W-1:0] MAX_PEAKS_RESET = 25'd1024;
  localparam logic [DIM_W-1:0] DIM_RESET = 13'd4096;

  typedef struct packed {
    logic [DIM_W-1:0] row;
    logic [DIM_W-1:0] col;
    logic             list_full;
  } peak_t;

  typedef struct packed {
    logic  push;
    peak_t data;
  } peak_push_t;

endpackage

// ===== hdl/lmat_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module lmat_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/lmat_front.sv =====
// Front end: sample intake, column buffers, 3x3 window, peak test and per-frame count.
module lmat_front #(
  parameter int MAX_ROWS = 4096,
  parameter int MAX_COLS = 4096,
  parameter int SAMPLE_WIDTH = 32
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [SAMPLE_WIDTH-1:0]      sample,
  input  logic signed [lmat_pkg::THR_W-1:0]   threshold,
  input  logic                                eight_neighbours,
  input  logic [lmat_pkg::CNT_W-1:0]          max_peaks,
  input  logic [lmat_pkg::DIM_W-1:0]          rows_eff,
  input  logic [lmat_pkg::DIM_W-1:0]          cols_eff,
  input  logic [lmat_pkg::Q_CNT_W-1:0]        q_count,
  output lmat_pkg::peak_push_t                q_push
);

  localparam int ROW_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int COL_W = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int CMP_W = (SAMPLE_WIDTH > lmat_pkg::THR_W) ? SAMPLE_WIDTH : lmat_pkg::THR_W;

  logic                           accept;
  logic [ROW_W-1:0]               row_pos;
  logic [COL_W-1:0]               col_pos;
  logic                           row_last;
  logic                           col_last;

  logic                           v1;
  logic signed [SAMPLE_WIDTH-1:0] s1;
  logic [ROW_W-1:0]               r1;
  logic [COL_W-1:0]               c1;
  logic                           last1;

  logic                           v2;
  logic [ROW_W-1:0]               r2;
  logic [COL_W-1:0]               c2;
  logic                           last2;

  logic [SAMPLE_WIDTH-1:0]        a_rd;
  logic [SAMPLE_WIDTH-1:0]        b_rd;
  logic signed [SAMPLE_WIDTH-1:0] win [3][3];

  logic [lmat_pkg::CNT_W-1:0]     peaks_found;
  logic [lmat_pkg::CNT_W-1:0]     peaks_inc;
  logic signed [CMP_W-1:0]        center_ext;
  logic signed [CMP_W-1:0]        thr_ext;
  logic                           edge_ok;
  logic                           corner_ok;
  logic                           is_peak;
  logic                           report;

  assign in_ready = (lmat_pkg::Q_CNT_W'(q_count) + lmat_pkg::Q_CNT_W'(v1)
                     + lmat_pkg::Q_CNT_W'(v2)) < lmat_pkg::Q_CNT_W'(lmat_pkg::Q_DEPTH);
  assign accept = in_valid & in_ready;

  assign row_last = (32'(row_pos) + 32'd1) >= 32'(rows_eff);
  assign col_last = (32'(col_pos) + 32'd1) >= 32'(cols_eff);

  always_ff @(posedge clk) begin
    if (rst) begin
      row_pos <= '0;
      col_pos <= '0;
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= accept;
      v2 <= v1;
      if (accept) begin
        if (row_last) begin
          row_pos <= '0;
          if (col_last) begin
            col_pos <= '0;
          end else begin
            col_pos <= col_pos + COL_W'(1);
          end
        end else begin
          row_pos <= row_pos + ROW_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1 <= sample;
      r1 <= row_pos;
      c1 <= col_pos;
      last1 <= row_last & col_last;
    end
    if (v1) begin
      r2 <= r1;
      c2 <= c1;
      last2 <= last1;
      for (int k = 0; k < 3; k++) begin
        win[k][0] <= win[k][1];
        win[k][1] <= win[k][2];
      end
      win[0][2] <= $signed(b_rd);
      win[1][2] <= $signed(a_rd);
      win[2][2] <= s1;
    end
  end

  lmat_ram #(
    .WIDTH(SAMPLE_WIDTH),
    .DEPTH(MAX_ROWS)
  ) u_buf_a (
    .clk  (clk),
    .we   (v1),
    .waddr(r1),
    .wdata(s1),
    .raddr(row_pos),
    .rdata(a_rd)
  );

  lmat_ram #(
    .WIDTH(SAMPLE_WIDTH),
    .DEPTH(MAX_ROWS)
  ) u_buf_b (
    .clk  (clk),
    .we   (v1),
    .waddr(r1),
    .wdata(a_rd),
    .raddr(row_pos),
    .rdata(b_rd)
  );

  assign center_ext = CMP_W'(win[1][1]);
  assign thr_ext = CMP_W'(threshold);
  assign edge_ok = (win[1][1] > win[0][1]) && (win[1][1] > win[2][1])
                && (win[1][1] > win[1][0]) && (win[1][1] > win[1][2]);
  assign corner_ok = (win[1][1] > win[0][0]) && (win[1][1] > win[2][0])
                  && (win[1][1] > win[0][2]) && (win[1][1] > win[2][2]);
  assign is_peak = (center_ext > thr_ext) && edge_ok && (!eight_neighbours || corner_ok);
  assign report = v2 && (32'(r2) >= 32'd2) && (32'(c2) >= 32'd2)
               && (peaks_found < max_peaks) && is_peak;
  assign peaks_inc = peaks_found + lmat_pkg::CNT_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      peaks_found <= '0;
    end else if (v2) begin
      if (last2) begin
        peaks_found <= '0;
      end else if (report) begin
        peaks_found <= peaks_inc;
      end
    end
  end

  always_comb begin
    q_push.push = report;
    q_push.data.row = lmat_pkg::DIM_W'(r2);
    q_push.data.col = lmat_pkg::DIM_W'(c2);
    q_push.data.list_full = peaks_inc >= max_peaks;
  end

endmodule

// ===== hdl/lmat_queue.sv =====
// Short queue of detected peaks between the front end and the back end.
module lmat_queue (
  input  logic                          clk,
  input  logic                          rst,
  input  lmat_pkg::peak_push_t          q_push,
  input  logic                          pop,
  output logic                          not_empty,
  output lmat_pkg::peak_t               head,
  output logic [lmat_pkg::Q_CNT_W-1:0]  count
);

  lmat_pkg::peak_t                 entries [lmat_pkg::Q_DEPTH];
  logic [lmat_pkg::Q_PTR_W-1:0]    wptr;
  logic [lmat_pkg::Q_PTR_W-1:0]    rptr;

  assign not_empty = count != '0;
  assign head = entries[rptr];

  always_ff @(posedge clk) begin
    if (q_push.push) begin
      entries[wptr] <= q_push.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      count <= '0;
    end else begin
      if (q_push.push) begin
        wptr <= wptr + lmat_pkg::Q_PTR_W'(1);
      end
      if (pop) begin
        rptr <= rptr + lmat_pkg::Q_PTR_W'(1);
      end
      if (q_push.push && !pop) begin
        count <= count + lmat_pkg::Q_CNT_W'(1);
      end else if (!q_push.push && pop) begin
        count <= count - lmat_pkg::Q_CNT_W'(1);
      end
    end
  end

endmodule

// ===== hdl/lmat_back.sv =====
// Back end: forms the linear index of each peak and holds the result register.
module lmat_back (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          q_not_empty,
  input  lmat_pkg::peak_t               q_head,
  output logic                          q_pop,
  input  logic [lmat_pkg::DIM_W-1:0]    rows_eff,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [lmat_pkg::CNT_W-1:0]    peak_index,
  output logic [lmat_pkg::DIM_W-1:0]    peak_row,
  output logic [lmat_pkg::DIM_W-1:0]    peak_col,
  output logic                          list_full
);

  logic [31:0] index_full;

  assign q_pop = q_not_empty && (!out_valid || out_ready);
  assign index_full = 32'(q_head.col - lmat_pkg::DIM_W'(1)) * 32'(rows_eff)
                    + 32'(q_head.row);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (q_pop) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      peak_index <= lmat_pkg::CNT_W'(index_full);
      peak_row <= q_head.row;
      peak_col <= q_head.col;
      list_full <= q_head.list_full;
    end
  end

endmodule

// ===== hdl/local_maximum_above_threshold.sv =====
// A peak passes from the sample register through the window registers and the peak queue into the output register.
// Throughput: one sample per clock; in_ready drops only while found peaks back up in the queue.
// The window path never stalls; the peak queue and the output register absorb output stalls.
// Reset clears positions, the peak count, the queue and the output valid, and loads register
// defaults; the column buffers are not cleared and are filled by each frame's first columns.
module local_maximum_above_threshold #(
  parameter int MAX_ROWS = 4096,
  parameter int MAX_COLS = 4096,
  parameter int SAMPLE_WIDTH = 32
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [SAMPLE_WIDTH-1:0]      sample,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [lmat_pkg::CNT_W-1:0]          peak_index,
  output logic [lmat_pkg::DIM_W-1:0]          peak_row,
  output logic [lmat_pkg::DIM_W-1:0]          peak_col,
  output logic                                list_full,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [lmat_pkg::ADDR_W-1:0]         paddr,
  input  logic [lmat_pkg::DATA_W-1:0]         pwdata,
  output logic [lmat_pkg::DATA_W-1:0]         prdata,
  output logic                                pready
);

  logic signed [lmat_pkg::THR_W-1:0] threshold;
  logic                              eight_neighbours;
  logic [lmat_pkg::CNT_W-1:0]        max_peaks;
  logic [lmat_pkg::DIM_W-1:0]        frame_rows;
  logic [lmat_pkg::DIM_W-1:0]        frame_cols;
  logic [lmat_pkg::DIM_W-1:0]        rows_eff;
  logic [lmat_pkg::DIM_W-1:0]        cols_eff;
  logic [lmat_pkg::REG_SEL_W-1:0]    reg_sel;
  logic                              wr_en;

  lmat_pkg::peak_push_t              q_push;
  lmat_pkg::peak_t                   q_head;
  logic                              q_not_empty;
  logic                              q_pop;
  logic [lmat_pkg::Q_CNT_W-1:0]      q_count;

  assign pready = 1'b1;
  assign reg_sel = paddr[lmat_pkg::ADDR_W-1:2];
  assign wr_en = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= lmat_pkg::THRESHOLD_RESET;
      eight_neighbours <= 1'b0;
      max_peaks <= lmat_pkg::MAX_PEAKS_RESET;
      frame_rows <= lmat_pkg::DIM_RESET;
      frame_cols <= lmat_pkg::DIM_RESET;
    end else if (wr_en) begin
      case (reg_sel)
        lmat_pkg::REG_THRESHOLD: begin
          threshold <= pwdata[lmat_pkg::THR_W-1:0];
        end
        lmat_pkg::REG_EIGHT_NEIGHBOURS: begin
          eight_neighbours <= pwdata[0];
        end
        lmat_pkg::REG_MAX_PEAKS: begin
          max_peaks <= pwdata[lmat_pkg::CNT_W-1:0];
        end
        lmat_pkg::REG_FRAME_ROWS: begin
          frame_rows <= pwdata[lmat_pkg::DIM_W-1:0];
        end
        lmat_pkg::REG_FRAME_COLS: begin
          frame_cols <= pwdata[lmat_pkg::DIM_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      lmat_pkg::REG_THRESHOLD:        prdata = threshold;
      lmat_pkg::REG_EIGHT_NEIGHBOURS: prdata = lmat_pkg::DATA_W'(eight_neighbours);
      lmat_pkg::REG_MAX_PEAKS:        prdata = lmat_pkg::DATA_W'(max_peaks);
      lmat_pkg::REG_FRAME_ROWS:       prdata = lmat_pkg::DATA_W'(frame_rows);
      lmat_pkg::REG_FRAME_COLS:       prdata = lmat_pkg::DATA_W'(frame_cols);
      default:                        prdata = '0;
    endcase
  end

  always_comb begin
    if (frame_rows < lmat_pkg::DIM_MIN) begin
      rows_eff = lmat_pkg::DIM_MIN;
    end else if (32'(frame_rows) > 32'(MAX_ROWS)) begin
      rows_eff = lmat_pkg::DIM_W'(MAX_ROWS);
    end else begin
      rows_eff = frame_rows;
    end
    if (frame_cols < lmat_pkg::DIM_MIN) begin
      cols_eff = lmat_pkg::DIM_MIN;
    end else if (32'(frame_cols) > 32'(MAX_COLS)) begin
      cols_eff = lmat_pkg::DIM_W'(MAX_COLS);
    end else begin
      cols_eff = frame_cols;
    end
  end

  lmat_front #(
    .MAX_ROWS    (MAX_ROWS),
    .MAX_COLS    (MAX_COLS),
    .SAMPLE_WIDTH(SAMPLE_WIDTH)
  ) u_front (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .sample          (sample),
    .threshold       (threshold),
    .eight_neighbours(eight_neighbours),
    .max_peaks       (max_peaks),
    .rows_eff        (rows_eff),
    .cols_eff        (cols_eff),
    .q_count         (q_count),
    .q_push          (q_push)
  );

  lmat_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .q_push   (q_push),
    .pop      (q_pop),
    .not_empty(q_not_empty),
    .head     (q_head),
    .count    (q_count)
  );

  lmat_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_not_empty(q_not_empty),
    .q_head     (q_head),
    .q_pop      (q_pop),
    .rows_eff   (rows_eff),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .peak_index (peak_index),
    .peak_row   (peak_row),
    .peak_col   (peak_col),
    .list_full  (list_full)
  );

endmodule
